[design/lsp_pkg.sv]
// Shared types and constants for the 3x3 Laplacian sharpening core.
`default_nettype none

package lsp_pkg;

    // Line store depth and row limit
    localparam int MAX_COLS_DEF = 1024;
    localparam int ROW_LIMIT    = 1024;

    // Result queue depth (covers the three pipeline stages plus slack)
    localparam int OUTQ_DEPTH   = 8;

    // Register field widths
    localparam int DIM_W  = 11;
    localparam int PIX_W  = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_COLS  = 2'd0;
    localparam logic [1:0] CFG_FRAME_ROWS  = 2'd1;
    localparam logic [1:0] CFG_MASK_SELECT = 2'd2;

    // Laplacian mask choice
    typedef enum logic [1:0] {
        MASK_FOUR_NEG  = 2'd0,
        MASK_EIGHT_NEG = 2'd1,
        MASK_FOUR_POS  = 2'd2,
        MASK_EIGHT_POS = 2'd3
    } t_mask;

    // One result item
    typedef struct packed {
        logic [PIX_W-1:0] sharp;
        logic [PIX_W-1:0] lap;
        logic             frame_end;
    } t_result;

endpackage

`default_nettype wire

[design/lsp_out_queue.sv]
// Small result queue that decouples the pipeline from the output handshake.
`default_nettype none

module lsp_out_queue #(
    parameter int DEPTH = lsp_pkg::OUTQ_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire lsp_pkg::t_result         i_push_data,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output lsp_pkg::t_result              o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    lsp_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_pop;

    assign w_pop   = (r_count != '0) && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)) || w_pop)
        else $error("result queue overflow");

    a_pop_drops_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("result queue level did not drop on transfer");
`endif

endmodule

`default_nettype wire

[design/laplacian_sharpen_3x3_core.sv]
// Streaming 3x3 Laplacian sharpening core: line stores, window and mask arithmetic.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_gray_in[7:0], i_drain
//  out     | source    | o_out_valid / i_out_ready  | o_sharp_out, o_lap_out, o_frame_end
//  cfg     | sink      | i_cfg_wr_en (no wait)      | i_cfg_index[1:0], i_cfg_wdata[10:0]
//
// One pixel per clock while o_in_ready=1; each line store has one read and one write port.
// Results pass the window, neighbor-sum and mask/queue stages before reaching the output.
// Same-column accesses on back-to-back transfers are forwarded around the line store write.
// Synchronous active-low reset; no clearing pass, line stores hold garbage until written.
// Output stalls fill an 8-entry result queue; o_in_ready drops once queue plus pipe is full.
`default_nettype none

module laplacian_sharpen_3x3_core #(
    parameter int MAX_COLS = lsp_pkg::MAX_COLS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [lsp_pkg::DIM_W-1:0] i_cfg_wdata,
    // pixel input
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [7:0]               i_gray_in,
    input  wire logic                     i_drain,
    // result output
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [7:0]                    o_sharp_out,
    output logic [7:0]                    o_lap_out,
    output logic                          o_frame_end
);

    localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNTW = $clog2(MAX_COLS+1);
    localparam int CMPW = (CNTW > lsp_pkg::DIM_W) ? CNTW : lsp_pkg::DIM_W;
    localparam int RW   = lsp_pkg::DIM_W;
    localparam int QD   = lsp_pkg::OUTQ_DEPTH;
    localparam int QCW  = $clog2(QD+1);

    // Configuration registers
    logic [RW-1:0]         r_frame_cols;
    logic [RW-1:0]         r_frame_rows;
    lsp_pkg::t_mask        r_mask_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols  <= RW'(512);
            r_frame_rows  <= RW'(512);
            r_mask_select <= lsp_pkg::MASK_EIGHT_POS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lsp_pkg::CFG_FRAME_COLS:  r_frame_cols  <= i_cfg_wdata;
                lsp_pkg::CFG_FRAME_ROWS:  r_frame_rows  <= i_cfg_wdata;
                lsp_pkg::CFG_MASK_SELECT: r_mask_select <= lsp_pkg::t_mask'(i_cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    // Clamped frame dimensions
    logic [CMPW-1:0] w_fc;
    logic [CMPW-1:0] w_ncols;
    logic [RW-1:0]   w_nrows;

    assign w_fc = CMPW'(r_frame_cols);

    always_comb begin
        if (w_fc < CMPW'(3))             w_ncols = CMPW'(3);
        else if (w_fc > CMPW'(MAX_COLS)) w_ncols = CMPW'(MAX_COLS);
        else                             w_ncols = w_fc;
        if (r_frame_rows < RW'(3))                          w_nrows = RW'(3);
        else if (r_frame_rows > RW'(lsp_pkg::ROW_LIMIT))    w_nrows = RW'(lsp_pkg::ROW_LIMIT);
        else                                                w_nrows = r_frame_rows;
    end

    // Handshake and pipeline occupancy
    logic             w_in_xfer;
    logic             r_s1_valid;
    logic             r_s2_valid;
    logic             r_s3_valid;
    logic [QCW-1:0]   w_q_count;
    logic [QCW:0]     w_occupancy;

    assign w_occupancy = (QCW+1)'(w_q_count) + (QCW+1)'(r_s1_valid)
                       + (QCW+1)'(r_s2_valid) + (QCW+1)'(r_s3_valid);
    assign o_in_ready  = (w_occupancy <= (QCW+1)'(QD-1));
    assign w_in_xfer   = i_in_valid && o_in_ready;

    // Position tracking (stage 0)
    logic [AW-1:0]   r_col_count;
    logic [RW-1:0]   r_row_count;
    logic            w_restart;
    logic [AW-1:0]   w_col;
    logic [RW-1:0]   w_row;
    logic            w_emit;
    logic [AW-1:0]   w_cc;
    logic [RW-1:0]   w_cr;
    logic            w_last;
    logic            w_border;
    logic            w_row_wrap;
    logic [AW-1:0]   n_col_count;
    logic [RW-1:0]   n_row_count;

    always_comb begin
        w_restart = (CMPW'(r_col_count) >= w_ncols) || (r_row_count > w_nrows + 1'b1);
        w_col     = w_restart ? '0 : r_col_count;
        w_row     = w_restart ? '0 : r_row_count;
        w_emit    = (w_row >= RW'(2)) || ((w_row == RW'(1)) && (w_col != '0));
        if (w_col != '0) begin
            w_cr = w_row - 1'b1;
            w_cc = w_col - 1'b1;
        end else begin
            w_cr = (w_row >= RW'(2)) ? w_row - RW'(2) : '0;
            w_cc = AW'(w_ncols - 1'b1);
        end
        w_last   = w_emit && (w_cr == w_nrows - 1'b1) && (CMPW'(w_cc) == w_ncols - 1'b1);
        w_border = (w_cr == '0) || (w_cr >= w_nrows - 1'b1)
                || (w_cc == '0) || (CMPW'(w_cc) >= w_ncols - 1'b1);
        w_row_wrap = (CMPW'(w_col) + 1'b1 >= w_ncols);
        if (w_last) begin
            n_col_count = '0;
            n_row_count = '0;
        end else if (w_row_wrap) begin
            n_col_count = '0;
            n_row_count = w_row + 1'b1;
        end else begin
            n_col_count = w_col + 1'b1;
            n_row_count = w_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (w_in_xfer) begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
        end
    end

    // Stage 1 registers and forwarding
    logic [AW-1:0]   r_s1_col;
    logic [7:0]      r_s1_px;
    logic            r_s1_emit;
    logic            r_s1_last;
    logic            r_s1_border;
    logic            r_fwd;
    logic [7:0]      r_fwd_a;
    logic [7:0]      r_fwd_b;
    logic [7:0]      r_rd_a;
    logic [7:0]      r_rd_b;
    logic [7:0]      w_s1_above;
    logic [7:0]      w_s1_above2;
    logic            w_fwd_hit;

    assign w_fwd_hit   = r_s1_valid && (r_s1_col == w_col);
    assign w_s1_above  = r_fwd ? r_fwd_a : r_rd_a;
    assign w_s1_above2 = r_fwd ? r_fwd_b : r_rd_b;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_col    <= w_col;
            r_s1_px     <= i_drain ? 8'd0 : i_gray_in;
            r_s1_emit   <= w_emit;
            r_s1_last   <= w_last;
            r_s1_border <= w_border;
            r_fwd       <= w_fwd_hit;
            r_fwd_a     <= r_s1_px;
            r_fwd_b     <= w_s1_above;
        end
    end

    // Line stores: read at stage 0, write back at stage 1
    logic [7:0] r_line_a [MAX_COLS];
    logic [7:0] r_line_b [MAX_COLS];

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_rd_a <= r_line_a[w_col];
        end
        if (r_s1_valid) begin
            r_line_a[r_s1_col] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_rd_b <= r_line_b[w_col];
        end
        if (r_s1_valid) begin
            r_line_b[r_s1_col] <= w_s1_above;
        end
    end

    // 3x3 window, shifted once per pixel
    logic [7:0] r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (r_s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= w_s1_above2;
            r_win[1][2] <= w_s1_above;
            r_win[2][2] <= r_s1_px;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_xfer;
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Stage 2: neighbor sums from the updated window
    logic        r_s2_last;
    logic        r_s2_border;
    logic [9:0]  r_s3_four;
    logic [9:0]  r_s3_corn;
    logic [7:0]  r_s3_ctr;
    logic        r_s3_last;
    logic        r_s3_border;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_last   <= r_s1_last;
            r_s2_border <= r_s1_border;
        end
        if (r_s2_valid) begin
            r_s3_four   <= 10'(r_win[0][1]) + 10'(r_win[1][0])
                         + 10'(r_win[1][2]) + 10'(r_win[2][1]);
            r_s3_corn   <= 10'(r_win[0][0]) + 10'(r_win[0][2])
                         + 10'(r_win[2][0]) + 10'(r_win[2][2]);
            r_s3_ctr    <= r_win[1][1];
            r_s3_last   <= r_s2_last;
            r_s3_border <= r_s2_border;
        end
    end

    // Stage 3: mask response, clamp and saturating add
    logic signed [12:0] w_four;
    logic signed [12:0] w_corn;
    logic signed [12:0] w_ctr4;
    logic signed [12:0] w_ctr8;
    logic signed [12:0] w_lap_raw;
    logic [7:0]         w_lap;
    logic [8:0]         w_sum;
    lsp_pkg::t_result   w_result;

    always_comb begin
        w_four = $signed({3'b000, r_s3_four});
        w_corn = $signed({3'b000, r_s3_corn});
        w_ctr4 = $signed({3'b000, r_s3_ctr, 2'b00});
        w_ctr8 = $signed({2'b00, r_s3_ctr, 3'b000});
        case (r_mask_select)
            lsp_pkg::MASK_FOUR_NEG:  w_lap_raw = w_four - w_ctr4;
            lsp_pkg::MASK_EIGHT_NEG: w_lap_raw = w_four + w_corn - w_ctr8;
            lsp_pkg::MASK_FOUR_POS:  w_lap_raw = w_ctr4 - w_four;
            default:                 w_lap_raw = w_ctr8 - w_four - w_corn;
        endcase
        if (r_s3_border || w_lap_raw[12]) begin
            w_lap = 8'd0;
        end else if (w_lap_raw > 13'sd255) begin
            w_lap = 8'd255;
        end else begin
            w_lap = w_lap_raw[7:0];
        end
        w_sum              = {1'b0, r_s3_ctr} + {1'b0, w_lap};
        w_result.sharp     = w_sum[8] ? 8'd255 : w_sum[7:0];
        w_result.lap       = w_lap;
        w_result.frame_end = r_s3_last;
    end

    // Result queue
    lsp_pkg::t_result w_q_data;

    lsp_out_queue #(
        .DEPTH (QD)
    ) u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s3_valid),
        .i_push_data (w_result),
        .o_count     (w_q_count),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (w_q_data)
    );

    assign o_sharp_out = w_q_data.sharp;
    assign o_lap_out   = w_q_data.lap;
    assign o_frame_end = w_q_data.frame_end;

`ifndef ASSERT_OFF
    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occupancy <= (QCW+1)'(QD))
        else $error("pipeline plus queue exceeds queue depth");

    a_frame_end_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_lap_out == 8'd0))
        else $error("last pixel of a frame has nonzero Laplacian");

    a_sharp_ge_lap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sharp_out >= o_lap_out))
        else $error("sharpened value below Laplacian response");

    a_s3_follows_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> $past(r_s2_valid))
        else $error("stage 3 valid without stage 2 item");
`endif

endmodule

`default_nettype wire
